// ===== hdl/btpd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btpd_pkg
// Shared types and fixed constants of the band tone peak detector: register
// indexes, register reset values and widths of the fixed-size fields.
// ---------------------------------------------------------------------------
package btpd_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Register field widths
  localparam int BAND_W   = 17;
  localparam int LOG2_W   = 5;
  localparam int MARGIN_W = 16;

  // Margin factor (256 + margin) in Q9.8
  localparam int                  MARGIN_FRAC_W = 8;
  localparam int                  FACTOR_W      = 17;
  localparam logic [FACTOR_W-1:0] MARGIN_ONE    = 17'd256;

  // Saturating magnitude sum, split in a low and a high part for the margin product
  localparam int SUM_W    = 49;
  localparam int SUM_LO_W = 25;
  localparam int SUM_HI_W = SUM_W - SUM_LO_W;
  localparam int RHS_W    = FACTOR_W + SUM_W;

  // Result width
  localparam int PEAK_W = 32;

  // Bin queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Register reset values
  localparam logic [LOG2_W-1:0]   LOG2_RESET   = 5'd10;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_START  = 2'd0,
    CFG_BAND_END    = 2'd1,
    CFG_LOG2_LENGTH = 2'd2,
    CFG_PEAK_MARGIN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [BAND_W-1:0]   band_start;
    logic [BAND_W-1:0]   band_end;
    logic [LOG2_W-1:0]   log2_length;
    logic [MARGIN_W-1:0] peak_margin;
  } cfg_t;

endpackage

// ===== hdl/btpd_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btpd_front
// Accepts spectrum bins, numbers them, marks bins inside the search band and
// pushes magnitude-ready absolute parts into the bin queue.
// ---------------------------------------------------------------------------
module btpd_front #(
  parameter int BIN_WIDTH = 32,
  parameter int CNT_W     = 17,
  parameter int CMP_W     = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [BIN_WIDTH-1:0] in_bin_real,
  input  logic signed [BIN_WIDTH-1:0] in_bin_imag,
  input  logic                        in_last_bin,
  input  btpd_pkg::cfg_t              cfg,
  input  logic [CMP_W-1:0]            band_end_eff,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [2*BIN_WIDTH+1:0]      q_wr_data
);
  import btpd_pkg::*;

  logic [CNT_W-1:0]     bin_cnt_r;
  logic [CNT_W-1:0]     bin_cnt_nxt;
  logic [BIN_WIDTH-1:0] re_u;
  logic [BIN_WIDTH-1:0] im_u;
  logic [BIN_WIDTH-1:0] abs_re;
  logic [BIN_WIDTH-1:0] abs_im;
  logic [CMP_W-1:0]     idx_ext;
  logic                 in_band;

  // Accept while the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // Take absolute values of both parts
  assign re_u   = in_bin_real;
  assign im_u   = in_bin_imag;
  assign abs_re = re_u[BIN_WIDTH-1] ? (~re_u + BIN_WIDTH'(1)) : re_u;
  assign abs_im = im_u[BIN_WIDTH-1] ? (~im_u + BIN_WIDTH'(1)) : im_u;

  // Classify the bin against the band
  assign idx_ext = CMP_W'(bin_cnt_r);
  assign in_band = (idx_ext >= CMP_W'(cfg.band_start)) && (idx_ext < band_end_eff);

  assign q_wr_data = {abs_re, abs_im, in_last_bin, in_band};

  // Advance the bin number, restart after the last bin
  assign bin_cnt_nxt = in_last_bin ? '0 : bin_cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
    end else if (q_push) begin
      bin_cnt_r <= bin_cnt_nxt;
    end
  end

endmodule

// ===== hdl/btpd_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btpd_queue
// Small bin queue between front and back. Read data is registered and valid
// the cycle after a pop.
// ---------------------------------------------------------------------------
module btpd_queue #(
  parameter int DATA_W = 66
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output logic              full,
  output logic              empty
);
  import btpd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (pop) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/btpd_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btpd_back
// Pops queued bins, forms the integer magnitude with a two-bit-per-cycle
// square root, tracks peak and saturating sum, and on the last bin runs the
// peak-to-average test and loads the result register.
// ---------------------------------------------------------------------------
module btpd_back #(
  parameter int BIN_WIDTH = 32,
  parameter int CMP_W     = 17
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  logic [2*BIN_WIDTH+1:0]           q_rd_data,
  input  btpd_pkg::cfg_t                   cfg,
  input  logic [CMP_W-1:0]                 band_count,
  input  logic [btpd_pkg::LOG2_W-1:0]      eff_log2,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [btpd_pkg::PEAK_W-1:0]      out_peak_amplitude,
  output logic                             out_tone_found
);
  import btpd_pkg::*;

  localparam int MAG_W    = BIN_WIDTH;
  localparam int SQ_W     = 2 * BIN_WIDTH;
  localparam int ROOT_CYC = (BIN_WIDTH + 1) / 2;
  localparam int ROOT_W   = 2 * ROOT_CYC;
  localparam int X_W      = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 3;
  localparam int RCNT_W   = $clog2(ROOT_CYC + 1);
  localparam int LHS_W    = MAG_W + CMP_W;
  localparam int CMPX_W   = (RHS_W > LHS_W + MARGIN_FRAC_W) ? RHS_W : LHS_W + MARGIN_FRAC_W;
  localparam int PLO_W    = FACTOR_W + SUM_LO_W;
  localparam int PHI_W    = FACTOR_W + SUM_HI_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ADD,
    ST_ROOT,
    ST_ACC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CMP
  } state_t;

  state_t                state_r;
  logic                  last_r;
  logic [MAG_W-1:0]      peak_r;
  logic [SUM_W-1:0]      sum_r;
  logic                  out_valid_r;
  logic [PEAK_W-1:0]     out_amp_r;
  logic                  out_found_r;
  logic [RCNT_W-1:0]     rcnt_r;

  logic [SQ_W-1:0]       sq_re_r;
  logic [SQ_W-1:0]       sq_im_r;
  logic [X_W-1:0]        x_r;
  logic [REM_W-1:0]      rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [LHS_W-1:0]      lhs_r;
  logic [PLO_W-1:0]      pp_lo_r;
  logic [PHI_W-1:0]      pp_hi_r;

  logic [MAG_W-1:0]      rd_re;
  logic [MAG_W-1:0]      rd_im;
  logic                  rd_last;
  logic                  rd_in_band;
  logic [X_W-1:0]        x_nxt;
  logic [REM_W-1:0]      rem_nxt;
  logic [ROOT_W-1:0]     root_nxt;
  logic [REM_W-1:0]      trial;
  logic [MAG_W-1:0]      mag;
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_nxt;
  logic [FACTOR_W-1:0]   factor;
  logic [CMPX_W-1:0]     lhs_cmp;
  logic [CMPX_W-1:0]     rhs_cmp;
  logic                  found;
  logic [PEAK_W-1:0]     amp;
  logic                  out_free;

  // Unpack the queued bin
  assign {rd_re, rd_im, rd_last, rd_in_band} = q_rd_data;

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_ready;

  // Two digit steps of the square root per cycle
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    trial    = '0;
    for (int s = 0; s < 2; s++) begin
      rem_nxt = {rem_nxt[REM_W-3:0], x_nxt[X_W-1 -: 2]};
      trial   = REM_W'({root_nxt, 2'b01});
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
      end else begin
        root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
      end
      x_nxt = {x_nxt[X_W-3:0], 2'b00};
    end
  end

  // Saturate the running sum
  assign mag     = root_r[MAG_W-1:0];
  assign sum_ext = {1'b0, sum_r} + (SUM_W + 1)'(mag);
  assign sum_nxt = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  // Peak-to-average test: peak * count * 256 > (256 + margin) * sum
  assign factor  = MARGIN_ONE + FACTOR_W'(cfg.peak_margin);
  assign lhs_cmp = CMPX_W'(lhs_r) << MARGIN_FRAC_W;
  assign rhs_cmp = (CMPX_W'(pp_hi_r) << SUM_LO_W) + CMPX_W'(pp_lo_r);
  assign found   = (band_count != '0) && (sum_r != '0) && (lhs_cmp > rhs_cmp);
  assign amp     = found ? PEAK_W'(peak_r >> eff_log2) : '0;

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        sq_re_r <= rd_re * rd_re;
        sq_im_r <= rd_im * rd_im;
      end
      ST_ADD: begin
        x_r    <= X_W'(sq_re_r) + X_W'(sq_im_r);
        rem_r  <= '0;
        root_r <= '0;
      end
      ST_ROOT: begin
        x_r    <= x_nxt;
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
      end
      ST_MUL_LO: begin
        lhs_r   <= peak_r * band_count;
        pp_lo_r <= factor * sum_r[SUM_LO_W-1:0];
      end
      ST_MUL_HI: begin
        pp_hi_r <= factor * sum_r[SUM_W-1:SUM_LO_W];
      end
      default: begin
      end
    endcase
  end

  // Sequencer, accumulators and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      peak_r      <= '0;
      sum_r       <= '0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a new result, or drop the one just taken
      if ((state_r == ST_CMP) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          last_r <= rd_last;
          if (rd_in_band) begin
            state_r <= ST_ADD;
          end else if (rd_last) begin
            state_r <= ST_MUL_LO;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_ADD: begin
          rcnt_r  <= '0;
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          rcnt_r <= rcnt_r + RCNT_W'(1);
          if (rcnt_r == RCNT_W'(ROOT_CYC - 1)) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (mag > peak_r) begin
            peak_r <= mag;
          end
          sum_r   <= sum_nxt;
          state_r <= last_r ? ST_MUL_LO : ST_IDLE;
        end
        ST_MUL_LO: begin
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          // Hold until the result register is free
          if (out_free) begin
            out_amp_r   <= amp;
            out_found_r <= found;
            peak_r      <= '0;
            sum_r       <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_peak_amplitude = out_amp_r;
  assign out_tone_found     = out_found_r;

endmodule

// ===== hdl/band_tone_peak_detector_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// band_tone_peak_detector_core
// Band-limited spectral peak detector: integer magnitude of in-band FFT bins,
// running peak and sum, and a division-free peak-to-average tone test.
// ---------------------------------------------------------------------------
// Bins enter at up to one per cycle, while the queue has room, into a
// four-entry queue. For an in-band bin the back end forms both squares,
// their sum and the square root, two result bits per cycle, then updates
// peak and sum; an out-of-band bin is only classified. A frame's last bin
// adds the margin product and compare, then the result is loaded into the
// output register, which waits there until taken while the next bins are
// already being worked on. Registers must be written through the cfg_ port
// only while no frame is in flight; the core does not enforce this.
module band_tone_peak_detector_core #(
  parameter int MAX_LOG2_LENGTH = 16,
  parameter int BIN_WIDTH       = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [BIN_WIDTH-1:0]       in_bin_real,
  input  logic signed [BIN_WIDTH-1:0]       in_bin_imag,
  input  logic                              in_last_bin,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [btpd_pkg::PEAK_W-1:0]       out_peak_amplitude,
  output logic                              out_tone_found,
  input  logic                              cfg_we,
  input  logic [btpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import btpd_pkg::*;

  localparam int CNT_W = MAX_LOG2_LENGTH + 1;
  localparam int CMP_W = (CNT_W > BAND_W) ? CNT_W : BAND_W;
  localparam int QD_W  = 2 * BIN_WIDTH + 2;

  cfg_t              cfg_r;
  logic [LOG2_W-1:0] eff_log2;
  logic [CMP_W-1:0]  band_len;
  logic [CMP_W-1:0]  band_end_ext;
  logic [CMP_W-1:0]  band_start_ext;
  logic [CMP_W-1:0]  band_end_eff;
  logic [CMP_W-1:0]  band_count;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  logic [QD_W-1:0]   q_wr_data;
  logic [QD_W-1:0]   q_rd_data;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.band_start  <= '0;
      cfg_r.band_end    <= '0;
      cfg_r.log2_length <= LOG2_RESET;
      cfg_r.peak_margin <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BAND_START:  cfg_r.band_start  <= cfg_wdata[BAND_W-1:0];
        CFG_BAND_END:    cfg_r.band_end    <= cfg_wdata[BAND_W-1:0];
        CFG_LOG2_LENGTH: cfg_r.log2_length <= cfg_wdata[LOG2_W-1:0];
        CFG_PEAK_MARGIN: cfg_r.peak_margin <= cfg_wdata[MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp length and band end, derive the band length
  assign eff_log2 = (cfg_r.log2_length > LOG2_W'(MAX_LOG2_LENGTH)) ?
                    LOG2_W'(MAX_LOG2_LENGTH) : cfg_r.log2_length;
  assign band_len       = CMP_W'(1) << eff_log2;
  assign band_end_ext   = CMP_W'(cfg_r.band_end);
  assign band_start_ext = CMP_W'(cfg_r.band_start);
  assign band_end_eff   = (band_end_ext > band_len) ? band_len : band_end_ext;
  assign band_count     = (band_end_eff > band_start_ext) ?
                          (band_end_eff - band_start_ext) : '0;

  btpd_front #(
    .BIN_WIDTH (BIN_WIDTH),
    .CNT_W     (CNT_W),
    .CMP_W     (CMP_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_bin_real  (in_bin_real),
    .in_bin_imag  (in_bin_imag),
    .in_last_bin  (in_last_bin),
    .cfg          (cfg_r),
    .band_end_eff (band_end_eff),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wr_data    (q_wr_data)
  );

  btpd_queue #(
    .DATA_W (QD_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  btpd_back #(
    .BIN_WIDTH (BIN_WIDTH),
    .CMP_W     (CMP_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .q_rd_data          (q_rd_data),
    .cfg                (cfg_r),
    .band_count         (band_count),
    .eff_log2           (eff_log2),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_peak_amplitude (out_peak_amplitude),
    .out_tone_found     (out_tone_found)
  );

endmodule

// ===== hdl/btpd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// btpd_checker
// Port-level checks on the band tone peak detector result channel and reset
// behavior, bound to the top level.
// ---------------------------------------------------------------------------
module btpd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [btpd_pkg::PEAK_W-1:0] out_peak_amplitude,
  input logic                        out_tone_found
);
  import btpd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_peak_amplitude) &&
                               $stable(out_tone_found))
    else $error("result changed while stalled");

  // Drop the amplitude when no tone is reported
  a_no_tone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tone_found |-> out_peak_amplitude == '0)
    else $error("amplitude nonzero without tone");

  // Leave reset ready for input and with no result
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind band_tone_peak_detector_core btpd_checker u_btpd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_peak_amplitude (out_peak_amplitude),
  .out_tone_found     (out_tone_found)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives spectrum bins into band_tone_peak_detector_core and checks every
// tone report against a cycle-free model of the band peak and sum. Covers
// register extremes, empty and short bands, length clamping, random frames
// with and without a tone, random idling, a stretch with no idling and a
// long output stall that backs up the input.
// ---------------------------------------------------------------------------
module testbench;
  import btpd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned RANDOM_BINS   = 1600;
  localparam int unsigned QUIET_BINS    = 200;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned HOLD_AFTER    = 20;
  localparam int unsigned MAX_LOG2      = 16;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } spectrum_bin_t;

  typedef struct packed {
    logic [31:0] peak_amplitude;
    logic        tone_found;
  } tone_report_t;

  typedef enum int {FRAME_TONE, FRAME_WIDE, FRAME_SILENT} frame_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_bin_real = '0;
  logic [31:0] in_bin_imag = '0;
  logic        in_last_bin = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [PEAK_W-1:0] out_peak_amplitude;
  logic        out_tone_found;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register copies used by the predictor
  logic [BAND_W-1:0]   band_lo     = '0;
  logic [BAND_W-1:0]   band_hi_raw = '0;
  logic [LOG2_W-1:0]   len_log2    = LOG2_RESET;
  logic [MARGIN_W-1:0] margin_q88  = MARGIN_RESET;

  // Frame accumulators of the predictor
  logic [16:0] bin_idx;
  logic [32:0] peak_mag;
  logic [48:0] mag_sum;

  spectrum_bin_t pending_bins[$];
  tone_report_t  tone_reports[$];

  int unsigned bins_queued = 0;
  int unsigned bins_accepted = 0;
  int unsigned reports_checked = 0;
  int unsigned tones_seen = 0;
  int unsigned settings_used = 0;
  int unsigned in_stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          gaps_on = 1'b1;
  bit          bin_taken = 1'b0;

  band_tone_peak_detector_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_bin_real       (in_bin_real),
    .in_bin_imag       (in_bin_imag),
    .in_last_bin       (in_last_bin),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_peak_amplitude(out_peak_amplitude),
    .out_tone_found    (out_tone_found),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Magnitude of one two's complement part
  function automatic logic [31:0] part_abs(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Integer square root, one result bit at a time from the top
  function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[31:0];
  endfunction

  // Fold one accepted bin into the frame; on the last bin, queue the report
  task automatic track_spectrum_bin(input logic [31:0] re, input logic [31:0] im,
                                    input logic last);
    logic [4:0]   l2;
    logic [17:0]  span_len;
    logic [17:0]  end_eff;
    logic [63:0]  re_a, im_a;
    logic [31:0]  mag;
    logic [49:0]  sum_next;
    logic [17:0]  count;
    logic [65:0]  lhs, rhs, op_a, op_b;
    tone_report_t rep;
    l2       = (len_log2 > MAX_LOG2) ? 5'(MAX_LOG2) : len_log2;
    span_len = 18'd1 << l2;
    end_eff  = ({1'b0, band_hi_raw} > span_len) ? span_len : {1'b0, band_hi_raw};
    if ({1'b0, bin_idx} >= {1'b0, band_lo} && {1'b0, bin_idx} < end_eff) begin
      re_a = part_abs(re);
      im_a = part_abs(im);
      mag  = floor_sqrt(re_a * re_a + im_a * im_a);
      if ({1'b0, mag} > peak_mag) peak_mag = {1'b0, mag};
      sum_next = {1'b0, mag_sum} + mag;
      mag_sum  = sum_next[49] ? {49{1'b1}} : sum_next[48:0];
    end
    bin_idx = bin_idx + 17'd1;
    if (last) begin
      count = (end_eff > {1'b0, band_lo}) ? end_eff - {1'b0, band_lo} : '0;
      op_a = peak_mag;
      op_b = count;
      lhs  = (op_a * op_b) << 8;
      // (1 + margin) in Q9.8 times the sum
      op_a = 17'd256 + margin_q88;
      op_b = mag_sum;
      rhs  = op_a * op_b;
      rep.tone_found     = (count != 0) && (mag_sum != 0) && (lhs > rhs);
      rep.peak_amplitude = rep.tone_found ? 32'(peak_mag >> l2) : '0;
      if (rep.tone_found) tones_seen++;
      tone_reports = {tone_reports, rep};
      bin_idx  = '0;
      peak_mag = '0;
      mag_sum  = '0;
    end
  endtask

  // Check results, then advance the predictor on an accepted bin
  always @(posedge clk) begin
    tone_report_t want;
    if (!rst_n) begin
      bin_idx   = '0;
      peak_mag  = '0;
      mag_sum   = '0;
      bin_taken <= 1'b0;
    end else begin
      bin_taken <= in_valid && in_ready;
      if (in_valid && !in_ready) in_stall_cycles++;
      if (out_valid && out_ready) begin
        if (tone_reports.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result: expected none, got amplitude %0d tone %0b",
                   $time, out_peak_amplitude, out_tone_found);
        end else begin
          want = tone_reports.pop_front();
          reports_checked++;
          if (out_peak_amplitude !== want.peak_amplitude) begin
            errors++;
            $display("%0t ns: peak_amplitude expected %0d, got %0d",
                     $time, want.peak_amplitude, out_peak_amplitude);
          end
          if (out_tone_found !== want.tone_found) begin
            errors++;
            $display("%0t ns: tone_found expected %0b, got %0b",
                     $time, want.tone_found, out_tone_found);
          end
        end
      end
      if (in_valid && in_ready) begin
        track_spectrum_bin(in_bin_real, in_bin_imag, in_last_bin);
        bins_accepted++;
      end
    end
  end

  // Offer the next bin once the current one is taken; idle at random while gaps are on
  always @(negedge clk) begin
    spectrum_bin_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || bin_taken) begin
      if (pending_bins.size() != 0 && !(gaps_on && $urandom_range(99) < 14)) begin
        nxt = pending_bins.pop_front();
        in_valid    <= 1'b1;
        in_bin_real <= nxt.re;
        in_bin_imag <= nxt.im;
        in_last_bin <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls while gaps are on, plus one long hold-off while bins back up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reports_checked >= HOLD_AFTER &&
                 bins_queued - bins_accepted > 16) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (gaps_on && $urandom_range(99) < 14) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports outstanding",
               cycle_count, tone_reports.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void push_bin(input logic [31:0] re, input logic [31:0] im,
                                   input logic last);
    spectrum_bin_t b;
    b.re   = re;
    b.im   = im;
    b.last = last;
    pending_bins = {pending_bins, b};
    bins_queued++;
  endfunction

  function automatic logic [31:0] small_noise(input int unsigned amp);
    logic [31:0] v;
    v = $urandom_range(0, 2 * amp);
    return v - amp;
  endfunction

  // Queue one frame; a tone frame is low noise with one strong bin
  function automatic void queue_frame(input int unsigned n_bins, input frame_style_t style,
                                      input int unsigned spike_at);
    int unsigned amp;
    logic [31:0] re, im;
    amp = 1 << $urandom_range(0, 12);
    for (int unsigned i = 0; i < n_bins; i++) begin
      case (style)
        FRAME_TONE: begin
          if (i == spike_at) begin
            re = $urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(8, 24));
            im = $urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(8, 24));
          end else begin
            re = small_noise(amp);
            im = small_noise(amp);
          end
        end
        FRAME_WIDE: begin
          re = $urandom;
          im = $urandom;
        end
        default: begin
          re = '0;
          im = '0;
        end
      endcase
      push_bin(re, im, i == n_bins - 1);
    end
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_BAND_START:  band_lo     = value[BAND_W-1:0];
      CFG_BAND_END:    band_hi_raw = value[BAND_W-1:0];
      CFG_LOG2_LENGTH: len_log2    = value[LOG2_W-1:0];
      CFG_PEAK_MARGIN: margin_q88  = value[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  // Write all four registers, then return on a rising edge
  task automatic apply_config(input logic [16:0] lo, input logic [16:0] hi,
                              input logic [4:0] l2, input logic [15:0] margin);
    write_reg(CFG_BAND_START, lo);
    write_reg(CFG_BAND_END, hi);
    write_reg(CFG_LOG2_LENGTH, 17'(l2));
    write_reg(CFG_PEAK_MARGIN, 17'(margin));
    @(negedge clk) cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Wait for every queued bin and report, then let the back end go quiet
  task automatic drain_reports();
    while (bins_accepted != bins_queued || tone_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned goal, l2, span, lo, hi, margin, frames, n, r, spike_at;
    frame_style_t style;

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: empty band, so no tone
    push_bin(32'd100, 32'd0, 1'b0);
    push_bin(32'd0, -32'sd100, 1'b1);
    drain_reports();

    // Band [1,5) of 16 bins, ratio must beat 2
    apply_config(17'd1, 17'd5, 5'd4, 16'd256);
    push_bin(32'd0, 32'd0, 1'b0);
    push_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_bin(32'h8000_0000, 32'h8000_0000, 1'b0);
    push_bin(32'd1, -32'sd1, 1'b0);
    push_bin(32'd0, 32'h8000_0000, 1'b1);
    // Clear tone; the huge bin lies outside the band
    push_bin(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_bin(32'd0, 32'd0, 1'b0);
    push_bin(32'd1000, 32'd0, 1'b0);
    push_bin(32'd0, -32'sd1, 1'b0);
    push_bin(-32'sd3, 32'd4, 1'b1);
    // Short frame still divides by the full band length
    push_bin(32'd0, 32'd0, 1'b0);
    push_bin(32'd7, 32'd0, 1'b1);
    // No energy in band
    queue_frame(3, FRAME_SILENT, 0);
    push_bin(32'd5, 32'd5, 1'b1);
    drain_reports();

    // Length register above the maximum, end past the transform length
    apply_config(17'd0, 17'h1FFFF, 5'd31, 16'd0);
    push_bin(32'd3, 32'd4, 1'b0);
    push_bin(32'd0, 32'd0, 1'b0);
    push_bin(32'h7FFF_FFFF, 32'd0, 1'b1);
    drain_reports();

    // Length of one bin
    apply_config(17'd0, 17'd5, 5'd0, 16'd0);
    push_bin(32'd9, 32'd12, 1'b0);
    push_bin(32'd100, 32'd100, 1'b1);
    drain_reports();

    // Start at the top of the range, largest margin
    apply_config(17'h10000, 17'h10000, 5'd16, 16'hFFFF);
    push_bin(32'd1, 32'd1, 1'b1);
    drain_reports();

    // Start above end
    apply_config(17'd3, 17'd2, 5'd3, 16'hFFFF);
    push_bin(32'd2, 32'd2, 1'b0);
    push_bin(32'd4, 32'd4, 1'b1);
    drain_reports();

    // Margin too large for any tone
    apply_config(17'd0, 17'd8, 5'd3, 16'hFFFF);
    push_bin(32'h8000_0000, 32'd0, 1'b0);
    push_bin(32'd1, 32'd0, 1'b1);
    drain_reports();

    // Random settings, each with a handful of frames
    gaps_on = 1'b1;
    goal = bins_queued + RANDOM_BINS;
    while (bins_queued < goal) begin
      r = $urandom_range(99);
      if (r < 85)      l2 = $urandom_range(2, 5);
      else if (r < 90) l2 = $urandom_range(0, 1);
      else if (r < 95) l2 = $urandom_range(16, 31);
      else             l2 = $urandom_range(6, 15);
      span = (l2 <= 5) ? (1 << l2) : 32;
      lo = $urandom_range(0, span);
      r = $urandom_range(99);
      if (r < 80)      hi = lo + $urandom_range(1, span);
      else if (r < 90) hi = $urandom_range(0, lo);
      else             hi = $urandom_range(0, 17'h1FFFF);
      r = $urandom_range(99);
      if (r < 25)      margin = 0;
      else if (r < 75) margin = $urandom_range(0, 767);
      else             margin = $urandom_range(0, 16'hFFFF);
      apply_config(17'(lo), 17'(hi), 5'(l2), 16'(margin));
      frames = $urandom_range(4, 10);
      repeat (frames) begin
        n = $urandom_range(1, span + 4);
        r = $urandom_range(99);
        if (r < 70)      style = FRAME_TONE;
        else if (r < 90) style = FRAME_WIDE;
        else             style = FRAME_SILENT;
        spike_at = ($urandom_range(99) < 70) ? lo + $urandom_range(0, 2)
                                              : $urandom_range(0, n - 1);
        queue_frame(n, style, spike_at);
      end
      drain_reports();
    end

    // A long stretch with no idling on either side
    apply_config(17'd2, 17'd10, 5'd4, 16'd128);
    gaps_on = 1'b0;
    goal = bins_queued + QUIET_BINS;
    while (bins_queued < goal) begin
      queue_frame(16, FRAME_TONE, $urandom_range(2, 9));
    end
    drain_reports();

    $display("Covered %0d bins in %0d frames over %0d register settings, %0d with a tone",
             bins_accepted, reports_checked, settings_used, tones_seen);
    $display("Input stalled for %0d cycles, including a %0d-cycle result hold-off",
             in_stall_cycles, HOLD_CYCLES);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/btpd_pkg.sv
hdl/btpd_front.sv
hdl/btpd_queue.sv
hdl/btpd_back.sv
hdl/band_tone_peak_detector_core.sv
hdl/btpd_checker.sv
test/testbench.sv
